/* sv/elst_pkg.sv */
// Package for the event latency statistics table.
// Holds the command codes, the controller state type and the entry layout.
// No dependencies.
package elst_pkg;

  // Command codes carried by the cmd field.
  localparam logic [1:0] CMD_COUNT   = 2'd0;
  localparam logic [1:0] CMD_LATENCY = 2'd1;
  localparam logic [1:0] CMD_CLEAR   = 2'd2;

  // One statistics entry as it is kept in the table memory.
  typedef struct packed {
    logic [63:0] count;
    logic [63:0] total;
    logic [63:0] min;
    logic [63:0] max;
  } entry_t;

  // Value of an entry that has never been touched since reset or clear.
  localparam entry_t ENTRY_EMPTY = '{count: 64'd0, total: 64'd0,
                                     min: {64{1'b1}}, max: 64'd0};

  // Controller states.
  typedef enum logic {
    S_IDLE,
    S_CALC
  } state_t;

endpackage

/* sv/elst_stat_ram.sv */
// Statistics table memory with one write port and one registered read port.
// Per-entry valid bits let a clear drop every entry at once.
// Depends on elst_pkg.
module elst_stat_ram
  import elst_pkg::*;
#(
  parameter int DEPTH = 16,
  parameter int AW    = 4
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          rd_en,
  input  logic [AW-1:0] rd_addr,
  output entry_t        rd_entry,
  input  logic          wr_en,
  input  logic [AW-1:0] wr_addr,
  input  entry_t        wr_entry,
  input  logic          clr
);

  entry_t           mem [DEPTH];
  logic [DEPTH-1:0] vld;
  entry_t           rd_data;
  logic             rd_vld;

  // Array write and registered read.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_entry;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

  // Valid bits: set on write, all dropped on reset or clear.
  always_ff @(posedge clk) begin
    if (rst || clr) begin
      vld <= '0;
    end else if (wr_en) begin
      vld[wr_addr] <= 1'b1;
    end
  end

  // Registered valid of the entry being read.
  always_ff @(posedge clk) begin
    if (rst) begin
      rd_vld <= 1'b0;
    end else if (rd_en) begin
      rd_vld <= vld[rd_addr] && !(clr);
    end
  end

  // An entry not written since the last clear reads as empty.
  assign rd_entry = rd_vld ? rd_data : ENTRY_EMPTY;

endmodule

/* sv/event_latency_stats_table.sv */
// Top level of the event latency statistics table.
// Holds the controller and the update logic; depends on elst_pkg and elst_stat_ram.
//
//   channel | handshake          | fields
//   --------+--------------------+-----------------------------------------------
//   input   | in_valid, in_ready | cmd, event_index, latency
//   output  | out_valid,out_ready| accepted, event_count, latency_total,
//           |                    | latency_min, latency_max
//
// Each word has an accept cycle in S_IDLE, which starts the table read, and an
// update cycle in S_CALC, which updates the entry, writes it back and loads the
// result register. With the registered table read in this read-modify-write, no
// new word is accepted until the last one leaves S_CALC. A clear goes through the
// same states; it drops all valid bits at once, so there is no clearing pass after
// reset. A result waiting on out_ready does not block the next accept, but the
// update cycle holds until the result register is free.
module event_latency_stats_table
  import elst_pkg::*;
#(
  parameter int NUM_EVENTS = 16
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [1:0]  cmd,
  input  logic [7:0]  event_index,
  input  logic [63:0] latency,
  output logic        out_valid,
  input  logic        out_ready,
  output logic        accepted,
  output logic [63:0] event_count,
  output logic [63:0] latency_total,
  output logic [63:0] latency_min,
  output logic [63:0] latency_max
);

  localparam int AW = (NUM_EVENTS > 1) ? $clog2(NUM_EVENTS) : 1;

  state_t        state;
  state_t        state_next;
  logic [1:0]    cmd_q;
  logic          hit_q;
  logic [AW-1:0] idx_q;
  logic [63:0]   lat_q;
  logic          in_take;
  logic          calc_go;
  logic          do_upd;
  logic          wr_en;
  logic          clr;
  logic          in_range;
  entry_t        cur;
  entry_t        upd;
  entry_t        res;
  logic          res_acc;

  // Index check against the table depth.
  assign in_range = ({1'b0, event_index} < 9'(NUM_EVENTS));

  elst_stat_ram #(
    .DEPTH (NUM_EVENTS),
    .AW    (AW)
  ) u_ram (
    .clk      (clk),
    .rst      (rst),
    .rd_en    (in_take),
    .rd_addr  (event_index[AW-1:0]),
    .rd_entry (cur),
    .wr_en    (wr_en),
    .wr_addr  (idx_q),
    .wr_entry (upd),
    .clr      (clr)
  );

  // State register.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Next state and handshake controls.
  always_comb begin
    state_next = state;
    in_ready   = 1'b0;
    calc_go    = 1'b0;
    case (state)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          state_next = S_CALC;
        end
      end
      S_CALC: begin
        if (!out_valid || out_ready) begin
          calc_go    = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  assign in_take = in_valid && in_ready;

  // Capture the accepted word.
  always_ff @(posedge clk) begin
    if (in_take) begin
      cmd_q <= cmd;
      hit_q <= in_range;
      idx_q <= event_index[AW-1:0];
      lat_q <= latency;
    end
  end

  // Entry update and result selection.
  always_comb begin
    upd       = cur;
    upd.count = cur.count + 64'd1;
    if (cmd_q == CMD_LATENCY) begin
      upd.total = cur.total + lat_q;
      if (lat_q > cur.max) begin
        upd.max = lat_q;
      end
      if (lat_q < cur.min) begin
        upd.min = lat_q;
      end
    end
    do_upd = hit_q && ((cmd_q == CMD_COUNT) || (cmd_q == CMD_LATENCY));
    if (cmd_q == CMD_CLEAR) begin
      res_acc = 1'b1;
      res     = ENTRY_EMPTY;
    end else if (do_upd) begin
      res_acc = 1'b1;
      res     = upd;
    end else begin
      res_acc = 1'b0;
      res     = ENTRY_EMPTY;
    end
  end

  assign wr_en = calc_go && do_upd;
  assign clr   = calc_go && (cmd_q == CMD_CLEAR);

  // Result valid flag.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (calc_go) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  // Result payload register.
  always_ff @(posedge clk) begin
    if (calc_go) begin
      accepted      <= res_acc;
      event_count   <= res.count;
      latency_total <= res.total;
      latency_min   <= res.min;
      latency_max   <= res.max;
    end
  end

`ifndef SYNTHESIS
  // An accepted word always moves the controller into the update cycle.
  a_take_calc: assert property (@(posedge clk) disable iff (rst)
    in_take |=> (state == S_CALC))
    else $error("accepted word did not enter the update cycle");

  // A new result appears only right after an update cycle.
  a_res_src: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> ($past(state) == S_CALC))
    else $error("result appeared without an update cycle");

  // The table is written only for an in-range count or latency word.
  a_wr_legal: assert property (@(posedge clk) disable iff (rst)
    wr_en |-> ((state == S_CALC) && hit_q && (cmd_q != CMD_CLEAR)))
    else $error("table written outside a legal update");

  // An ignored word reports the empty entry.
  a_ign_empty: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !accepted) |-> ((event_count == 64'd0) && (latency_max == 64'd0)
                                  && (latency_min == {64{1'b1}})))
    else $error("ignored word did not report the empty entry");
`endif

endmodule
